/* rtl/mbs_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot shader package
// Shared constants, types and the palette function of the escape-time shader.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // Canvas and iteration limits.
  localparam int unsigned CANVAS_WIDTH   = 1024;
  localparam int unsigned CANVAS_HEIGHT  = 768;
  localparam int unsigned MAX_ITERATIONS = 96;

  // Field widths.
  localparam int unsigned PIX_W    = 10;
  localparam int unsigned CENTRE_W = 19;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned ESC_W    = 7;
  localparam int unsigned CFG_W    = 19;

  // Fixed-point datapath widths. Z_W holds c and z for any canvas size in range.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Z_W       = 30;
  localparam int unsigned PROD_W    = 2 * Z_W;
  localparam int unsigned SQ_W      = PROD_W - FRAC_BITS;
  localparam int unsigned ESCAPE_LIMIT = 4 * 65536;

  // Iteration counter and palette index widths.
  localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned IDX_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  // Palette colors.
  localparam logic [COLOUR_W-1:0] INSIDE_COLOUR = 24'h05070C;
  localparam logic [COLOUR_W-1:0] DEEP_BLUE     = 24'h081226;
  localparam logic [COLOUR_W-1:0] GOLD          = 24'hD4AF37;
  localparam logic [COLOUR_W-1:0] WARM_WHITE    = 24'hFFF3D0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CENTRE_REAL = 1'b0,
    REG_PIXEL_STEP  = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_DONE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_CHECK,
    ST_SHADE
  } state_e;

  // Operand selection for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_MAP_X,
    MUL_MAP_Y,
    MUL_ZXX,
    MUL_ZYY,
    MUL_ZXY
  } mul_sel_e;

  // Datapath controls issued by the sequencer.
  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_x0;
    logic     ld_y0;
    logic     init_z;
    logic     upd_zy;
    logic     ld_zx2;
    logic     iterate;
    logic     shade;
  } ctrl_t;

  // Blend two colors per channel with weight w out of 255, truncated.
  function automatic logic [COLOUR_W-1:0] blend(logic [COLOUR_W-1:0] a,
                                                logic [COLOUR_W-1:0] b,
                                                int unsigned w);
    logic [COLOUR_W-1:0] res;
    int unsigned ca;
    int unsigned cb;
    int unsigned c;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca = int'(a[ch*8 +: 8]);
      cb = int'(b[ch*8 +: 8]);
      c  = (ca * (255 - w) + cb * w) / 255;
      res[ch*8 +: 8] = c[7:0];
    end
    return res;
  endfunction

  // Shaded color for an escape count; only ever evaluated on constants.
  function automatic logic [COLOUR_W-1:0] palette_colour(int unsigned cnt);
    int unsigned t;
    logic [COLOUR_W-1:0] res;
    t = (cnt * 255) / MAX_ITERATIONS;
    if (cnt >= MAX_ITERATIONS) begin
      res = INSIDE_COLOUR;
    end else if (t < 128) begin
      res = blend(DEEP_BLUE, GOLD, t * 2);
    end else begin
      res = blend(GOLD, WARM_WHITE, (t - 128) * 2);
    end
    return res;
  endfunction

endpackage

/* rtl/mbs_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed Z_W by Z_W multiplier with a registered product, used for both the
// coordinate mapping and every product of the iteration.
// ----------------------------------------------------------------------------
module mbs_mul
  import mbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [Z_W-1:0]    a_i,
  input  logic signed [Z_W-1:0]    b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  // Full-width signed product.
  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  // Product register, loaded only when a new operation is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/mbs_shade.sv */
// ----------------------------------------------------------------------------
// Palette shader
// Maps the final escape count to a color through a constant palette table and
// presents the result for one cycle with its strobe.
// ----------------------------------------------------------------------------
module mbs_shade
  import mbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [CNT_W-1:0]    count_i,
  output logic                done_o,
  output logic [COLOUR_W-1:0] colour_o,
  output logic [ESC_W-1:0]    escape_o
);

  logic [COLOUR_W-1:0] pal_table [MAX_ITERATIONS];
  logic [COLOUR_W-1:0] colour_d;
  logic [COLOUR_W-1:0] colour_q;
  logic [ESC_W-1:0]    escape_q;
  logic                done_q;

  // Constant palette, one entry per count below the limit.
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_pal
    assign pal_table[g] = palette_colour(g);
  end

  // Points that never escaped get the inside color.
  assign colour_d = (count_i == CNT_W'(MAX_ITERATIONS)) ? INSIDE_COLOUR
                                                        : pal_table[count_i[IDX_W-1:0]];

  // Result strobe lasts exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= load_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      colour_q <= colour_d;
      escape_q <= ESC_W'(count_i);
    end
  end

  assign done_o   = done_q;
  assign colour_o = colour_q;
  assign escape_o = escape_q;

endmodule

/* rtl/mandelbrot_escape_time_shader.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time shader
// Maps a pixel to a signed 14.16 point, iterates z = z^2 + c and shades the count.
// ----------------------------------------------------------------------------
// One pixel transaction is taken when start is high and busy is low; busy then
// stays high until the result is out. A single multiplier forms every product,
// three per iteration (zx*zx, zy*zy, zx*zy). From the accepting edge the
// sequencer steps through MAP_X, MAP_Y and MAP_DONE, then SQ_X, SQ_Y and CHECK
// once per escape check until the point escapes or reaches MAX_ITERATIONS, then
// SHADE, and done_o is raised by the shader's result register. The result is
// shown on pixel_colour_o and escape_count_o for exactly one cycle with done_o,
// and the receiver cannot stall it; capture it on that edge. A new transaction
// may be started in the same cycle that done_o is high. Configuration writes
// are taken at any time but must only be issued while busy is low.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_shader
  import mbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel transaction
  input  logic                start,
  output logic                busy,
  input  logic [PIX_W-1:0]    pixel_x_i,
  input  logic [PIX_W-1:0]    pixel_y_i,
  // Result
  output logic                done_o,
  output logic [COLOUR_W-1:0] pixel_colour_o,
  output logic [ESC_W-1:0]    escape_count_o,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic signed [CENTRE_W-1:0] centre_q;
  logic        [STEP_W-1:0]   step_q;
  logic        [PIX_W-1:0]    px_q;
  logic        [PIX_W-1:0]    py_q;
  logic signed [Z_W-1:0]      x0_q;
  logic signed [Z_W-1:0]      y0_q;
  logic signed [Z_W-1:0]      zx_q;
  logic signed [Z_W-1:0]      zy_q;
  logic signed [SQ_W-1:0]     zx2_q;
  logic        [CNT_W-1:0]    count_q;
  logic                       first_q;

  logic signed [Z_W-1:0]      mul_a;
  logic signed [Z_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SQ_W-1:0]     prod_sq;
  logic signed [SQ_W:0]       mag_sum;
  logic                       escaped;
  logic                       last_iter;
  logic signed [Z_W-1:0]      zx_next;
  logic signed [Z_W-1:0]      zy_next;
  logic signed [Z_W-1:0]      px_off;
  logic signed [Z_W-1:0]      py_off;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= CENTRE_W'(-39322);
      step_q   <= STEP_W'(350);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTRE_REAL: centre_q <= cfg_wdata_i[CENTRE_W-1:0];
        REG_PIXEL_STEP:  step_q   <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Column and row offsets from mid-canvas.
  assign px_off = Z_W'(px_q) - Z_W'(CANVAS_WIDTH / 2);
  assign py_off = Z_W'(py_q) - Z_W'(CANVAS_HEIGHT / 2);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl.mul_sel)
      MUL_MAP_X: begin
        mul_a = px_off;
        mul_b = Z_W'(step_q);
      end
      MUL_MAP_Y: begin
        mul_a = py_off;
        mul_b = Z_W'(step_q);
      end
      MUL_ZXX: begin
        mul_a = zx_q;
        mul_b = zx_q;
      end
      MUL_ZYY: begin
        mul_a = zy_q;
        mul_b = zy_q;
      end
      MUL_ZXY: begin
        mul_a = zx_q;
        mul_b = zy_q;
      end
      default: begin
        mul_a = zx_q;
        mul_b = zy_q;
      end
    endcase
  end

  mbs_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Squared term of the product register, and the escape test on |z|^2.
  assign prod_sq   = SQ_W'(prod >>> FRAC_BITS);
  assign mag_sum   = (SQ_W + 1)'(zx2_q) + (SQ_W + 1)'(prod_sq);
  assign escaped   = (mag_sum > (SQ_W + 1)'(ESCAPE_LIMIT));
  assign last_iter = (count_q == CNT_W'(MAX_ITERATIONS - 1));

  // Next z values; exact whenever the point has not escaped.
  assign zx_next = Z_W'(zx2_q - prod_sq + SQ_W'(x0_q));
  assign zy_next = Z_W'(prod >>> (FRAC_BITS - 1)) + y0_q;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (start) state_d = ST_MAP_X;
      ST_MAP_X:    state_d = ST_MAP_Y;
      ST_MAP_Y:    state_d = ST_MAP_DONE;
      ST_MAP_DONE: state_d = ST_SQ_X;
      ST_SQ_X:     state_d = ST_SQ_Y;
      ST_SQ_Y:     state_d = ST_CHECK;
      ST_CHECK: begin
        if (escaped || last_iter) begin
          state_d = ST_SHADE;
        end else begin
          state_d = ST_SQ_X;
        end
      end
      ST_SHADE:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl = '{mul_en: 1'b0, mul_sel: MUL_ZXY, default: 1'b0};
    case (state_q)
      ST_IDLE: ;
      ST_MAP_X: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_MAP_X;
      end
      ST_MAP_Y: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_MAP_Y;
        ctrl.ld_x0   = 1'b1;
      end
      ST_MAP_DONE: begin
        ctrl.ld_y0  = 1'b1;
        ctrl.init_z = 1'b1;
      end
      ST_SQ_X: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_ZXX;
        ctrl.upd_zy  = 1'b1;
      end
      ST_SQ_Y: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_ZYY;
        ctrl.ld_zx2  = 1'b1;
      end
      ST_CHECK: begin
        ctrl.mul_en  = !escaped;
        ctrl.mul_sel = MUL_ZXY;
        ctrl.iterate = !escaped;
      end
      ST_SHADE: begin
        ctrl.shade = 1'b1;
      end
      default: ;
    endcase
  end

  // Control bits of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= 1'b0;
    end else begin
      if (ctrl.init_z) begin
        count_q <= '0;
        first_q <= 1'b1;
      end else begin
        if (ctrl.iterate) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (ctrl.upd_zy) begin
          first_q <= 1'b0;
        end
      end
    end
  end

  // Pixel, point and z registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (ctrl.ld_x0) begin
      x0_q <= Z_W'(prod) + Z_W'(centre_q);
    end
    if (ctrl.ld_y0) begin
      y0_q <= Z_W'(prod);
    end
    if (ctrl.init_z) begin
      zx_q <= '0;
      zy_q <= '0;
    end else begin
      if (ctrl.iterate) begin
        zx_q <= zx_next;
      end
      // The first pass has no zx*zy product pending.
      if (ctrl.upd_zy && !first_q) begin
        zy_q <= zy_next;
      end
    end
    if (ctrl.ld_zx2) begin
      zx2_q <= prod_sq;
    end
  end

  mbs_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ctrl.shade),
    .count_i  (count_q),
    .done_o   (done_o),
    .colour_o (pixel_colour_o),
    .escape_o (escape_count_o)
  );

  assign busy = (state_q != ST_IDLE);

endmodule

/* rtl/mbs_checker.sv */
// ----------------------------------------------------------------------------
// Shader port checker
// Checks the transaction sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
module mbs_checker
  import mbs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [COLOUR_W-1:0] pixel_colour_o,
  input logic [ESC_W-1:0]    escape_count_o
);

  // An accepted transaction makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  // A result only appears once the block has finished, never while busy.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Finishing a transaction always presents its result.
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("transaction ended without a result");

  // Results never come in consecutive cycles.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A point that never escaped is shaded with the inside color.
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (escape_count_o == ESC_W'(MAX_ITERATIONS)) |->
      (pixel_colour_o == INSIDE_COLOUR))
    else $error("inside point not shaded with the inside color");

endmodule

bind mandelbrot_escape_time_shader mbs_checker u_mbs_checker (.*);
